// ===== rtl/mep_pkg.sv =====
// shared types and constants for the mandelbrot escape-time pixel block
`default_nettype none

package mep_pkg;

   // fixed-point format of the window edges and of z
   localparam int FRAC_BITS = 28;

   // magnitude of pixel * |range|: 12 bits times 32 bits
   localparam int DIV_BITS = 44;

   // configuration register indexes
   localparam logic [2:0] CSR_MIN_R        = 3'd0;
   localparam logic [2:0] CSR_MAX_R        = 3'd1;
   localparam logic [2:0] CSR_MIN_I        = 3'd2;
   localparam logic [2:0] CSR_MAX_I        = 3'd3;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd4;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd5;
   localparam logic [2:0] CSR_MAX_ITER     = 3'd6;

   // configuration reset values
   localparam logic signed [31:0] RST_MIN_R        = -32'sd536870912;
   localparam logic signed [31:0] RST_MAX_R        = 32'sd268435456;
   localparam logic signed [31:0] RST_MIN_I        = -32'sd402653184;
   localparam logic signed [31:0] RST_MAX_I        = 32'sd402653184;
   localparam logic [12:0]        RST_IMAGE_WIDTH  = 13'd1200;
   localparam logic [12:0]        RST_IMAGE_HEIGHT = 13'd800;
   localparam logic [15:0]        RST_MAX_ITER     = 16'd255;

   typedef struct packed {
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [15:0] iter_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request, clear z and count
      logic axis;       // 0 real, 1 imaginary
      logic range_en;   // register window range and low edge
      logic div_start;  // launch divider
      logic div_take;   // store mapped coordinate
      logic iter_mul;   // register the three products
      logic iter_upd;   // escape test and z update
      logic rsp_load;   // fill output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic iter_stop;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/mep_div.sv =====
// bit-serial restoring divider with floor rounding of a signed quotient
`default_nettype none

module mep_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [mep_pkg::DIV_BITS-1:0]         num,
   input  wire logic                                 neg,
   input  wire logic [12:0]                          den,
   output logic                                      done,
   output logic signed [mep_pkg::DIV_BITS:0]         quot
);

   localparam int CNT_W = $clog2(mep_pkg::DIV_BITS + 1);

   logic [mep_pkg::DIV_BITS-1:0] quo_ff;
   logic [12:0]                  rem_ff;
   logic [12:0]                  den_ff;
   logic                         neg_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff;
   logic                         fix_ff;
   logic                         done_ff;
   logic signed [mep_pkg::DIV_BITS:0] quot_ff;

   logic [13:0]                  trial;
   logic                         take;
   logic [12:0]                  rem_in;
   logic signed [mep_pkg::DIV_BITS:0] quot_in;

   assign trial  = {rem_ff, quo_ff[mep_pkg::DIV_BITS-1]};
   assign take   = (trial >= {1'b0, den_ff});
   assign rem_in = take ? 13'(trial - {1'b0, den_ff}) : trial[12:0];

   // negative floor: -(q+1) when inexact is ~q, -q when exact is ~q + 1
   always_comb begin
      if (neg_ff) begin
         quot_in = ~{1'b0, quo_ff} + {{mep_pkg::DIV_BITS{1'b0}}, (rem_ff == 13'd0)};
      end else begin
         quot_in = {1'b0, quo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            fix_ff  <= 1'b0;
            cnt_ff  <= CNT_W'(mep_pkg::DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               fix_ff  <= 1'b1;
            end
         end else if (fix_ff) begin
            fix_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         neg_ff <= neg;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[mep_pkg::DIV_BITS-2:0], take};
         rem_ff <= rem_in;
      end
      if (fix_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/mep_dp.sv =====
// datapath: configuration registers, coordinate mapping, iteration and result register
`default_nettype none

module mep_dp (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mep_pkg::req_type  req_data,
   output mep_pkg::rsp_type       rsp_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              csr_wr_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata,
   input  wire mep_pkg::cmd_type  cmd,
   output mep_pkg::sts_type       sts
);

   localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< mep_pkg::FRAC_BITS;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[31:0];
      end
   endfunction

   // configuration
   logic signed [31:0] min_r_ff, max_r_ff, min_i_ff, max_i_ff;
   logic [12:0]        width_ff, height_ff;
   logic [15:0]        max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_r_ff    <= mep_pkg::RST_MIN_R;
         max_r_ff    <= mep_pkg::RST_MAX_R;
         min_i_ff    <= mep_pkg::RST_MIN_I;
         max_i_ff    <= mep_pkg::RST_MAX_I;
         width_ff    <= mep_pkg::RST_IMAGE_WIDTH;
         height_ff   <= mep_pkg::RST_IMAGE_HEIGHT;
         max_iter_ff <= mep_pkg::RST_MAX_ITER;
      end else if (csr_wr_en) begin
         case (csr_index)
            mep_pkg::CSR_MIN_R:        min_r_ff    <= csr_wdata;
            mep_pkg::CSR_MAX_R:        max_r_ff    <= csr_wdata;
            mep_pkg::CSR_MIN_I:        min_i_ff    <= csr_wdata;
            mep_pkg::CSR_MAX_I:        max_i_ff    <= csr_wdata;
            mep_pkg::CSR_IMAGE_WIDTH:  width_ff    <= csr_wdata[12:0];
            mep_pkg::CSR_IMAGE_HEIGHT: height_ff   <= csr_wdata[12:0];
            mep_pkg::CSR_MAX_ITER:     max_iter_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // request capture
   logic [11:0] pix_x_ff, pix_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_x_ff <= req_data.pixel_x;
         pix_y_ff <= req_data.pixel_y;
      end
   end

   // mapping: lo + floor(pos * (hi - lo) / dim)
   logic signed [31:0] hi_sel, lo_sel;
   logic signed [32:0] range_w;
   logic               range_neg_in;
   logic [31:0]        range_abs_in;
   logic               range_neg_ff;
   logic [31:0]        range_abs_ff;
   logic signed [31:0] lo_ff;
   logic [11:0]        pos_sel;
   logic [12:0]        dim_sel;
   logic [12:0]        den;
   logic [mep_pkg::DIV_BITS-1:0] num;
   logic               div_done;
   logic signed [mep_pkg::DIV_BITS:0] quot;
   logic signed [63:0] map_sum;
   logic signed [31:0] map_in;
   logic signed [31:0] cr_ff, ci_ff;

   assign hi_sel  = cmd.axis ? max_i_ff : max_r_ff;
   assign lo_sel  = cmd.axis ? min_i_ff : min_r_ff;
   assign range_w = {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};
   assign range_neg_in = range_w[32];
   // |range| never exceeds 2^32 - 1
   assign range_abs_in = range_neg_in ? 32'(-range_w) : range_w[31:0];

   always_ff @(posedge clock) begin
      if (cmd.range_en) begin
         range_neg_ff <= range_neg_in;
         range_abs_ff <= range_abs_in;
         lo_ff        <= lo_sel;
      end
   end

   assign pos_sel = cmd.axis ? pix_y_ff : pix_x_ff;
   assign dim_sel = cmd.axis ? height_ff : width_ff;
   assign den     = (dim_sel == 13'd0) ? 13'd1 : dim_sel;
   assign num     = {{(mep_pkg::DIV_BITS-12){1'b0}}, pos_sel}
                  * {{(mep_pkg::DIV_BITS-32){1'b0}}, range_abs_ff};

   mep_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .neg   (range_neg_ff),
      .den   (den),
      .done  (div_done),
      .quot  (quot)
   );

   assign map_sum = 64'(lo_ff) + 64'(quot);
   assign map_in  = sat32(map_sum);

   always_ff @(posedge clock) begin
      if (cmd.div_take) begin
         if (cmd.axis) begin
            ci_ff <= map_in;
         end else begin
            cr_ff <= map_in;
         end
      end
   end

   // iteration z = z^2 + c
   logic signed [31:0] zr_ff, zi_ff;
   logic signed [63:0] prr_ff, pii_ff, pri_ff;
   logic signed [63:0] sq_r, sq_i, cross_term;
   logic signed [31:0] zr_in, zi_in;
   logic [15:0]        n_ff;
   logic               escape;
   logic               iter_stop;

   assign sq_r   = prr_ff >>> mep_pkg::FRAC_BITS;
   assign sq_i   = pii_ff >>> mep_pkg::FRAC_BITS;
   assign cross_term = pri_ff >>> (mep_pkg::FRAC_BITS - 1);
   assign escape = (sq_r + sq_i) >= ESC_LIMIT;
   assign iter_stop = (n_ff >= max_iter_ff) || escape;
   assign zr_in  = sat32(sq_r - sq_i + 64'(cr_ff));
   assign zi_in  = sat32(cross_term + 64'(ci_ff));

   always_ff @(posedge clock) begin
      if (cmd.iter_mul) begin
         prr_ff <= 64'(zr_ff) * 64'(zr_ff);
         pii_ff <= 64'(zi_ff) * 64'(zi_ff);
         pri_ff <= 64'(zr_ff) * 64'(zi_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zr_ff <= '0;
         zi_ff <= '0;
         n_ff  <= '0;
      end else if (cmd.iter_upd && !iter_stop) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
         n_ff  <= n_ff + 16'd1;
      end
   end

   // output register
   logic                 rsp_valid_ff;
   mep_pkg::rsp_type     rsp_ff;
   logic [15:0]          n_sq;

   assign n_sq = n_ff[7:0] * n_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.iter_count <= n_ff;
         rsp_ff.red        <= 8'd0;
         rsp_ff.green      <= n_sq[7:0];
         rsp_ff.blue       <= n_ff[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.div_done  = div_done;
   assign sts.iter_stop = iter_stop;
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule

`default_nettype wire

// ===== rtl/mep_ctrl.sv =====
// controller: sequences mapping, iteration and result hand-off
`default_nettype none

module mep_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mep_pkg::sts_type  sts,
   output mep_pkg::cmd_type       cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RANGE  = 7'b0000010,
      ST_START  = 7'b0000100,
      ST_WAIT   = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_UPD    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               axis_in  = 1'b0;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            cmd.range_en = 1'b1;
            state_in     = ST_START;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (sts.div_done) begin
               cmd.div_take = 1'b1;
               if (axis_ff) begin
                  state_in = ST_MUL;
               end else begin
                  axis_in  = 1'b1;
                  state_in = ST_RANGE;
               end
            end
         end
         ST_MUL: begin
            cmd.iter_mul = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            cmd.iter_upd = 1'b1;
            state_in     = sts.iter_stop ? ST_FINISH : ST_MUL;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_pixel_top.sv =====
// Mandelbrot escape-time pixel evaluator, top level.
//
// A request carries one pixel (pixel_x, pixel_y). It is accepted when
// req_valid is high and req_stall low; one response with the iteration
// count and its color follows on rsp_valid / rsp_stall.
// The pixel is mapped into the complex window held in the csr_ registers
// (written through csr_wr_en / csr_index / csr_wdata; the user must write
// them only while idle, the block does not enforce it), then z = z^2 + c
// runs in Q4.28 until |z|^2 reaches 4 or max_iter is hit. Each coordinate
// goes through range setup, divider launch and the one-bit-a-cycle divider
// shared by both axes. Each iteration registers the products, then tests
// and updates, plus one final test pass.
// One pixel is in work at a time; the next request is taken once the
// response has been moved into the output register, even if that
// register is still waiting on the receiver.
// A stalled response holds its value. Reset is synchronous: it clears
// the controller and the output valid and loads the default window.
`default_nettype none

module mandelbrot_escape_pixel_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mep_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mep_pkg::rsp_type       rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);

   mep_pkg::cmd_type cmd;
   mep_pkg::sts_type sts;

   mep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mep_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== rtl/mep_checker.sv =====
// port-level checks for the mandelbrot escape-time pixel block
`default_nettype none

module mep_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire mep_pkg::rsp_type  rsp_data
);

   // a stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one pixel in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a pixel is in work");

   a_red_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.red == 8'd0)
      else $error("red channel not zero");

   a_blue_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.blue == rsp_data.iter_count[7:0])
      else $error("blue does not match count");

   a_green_square: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.green ==
         8'(rsp_data.iter_count[7:0] * rsp_data.iter_count[7:0]))
      else $error("green does not match count squared");

endmodule

bind mandelbrot_escape_pixel_top mep_checker u_mep_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
